>>> src/clb_pkg.sv
package clb_pkg;

	localparam int MAX_ITEMS   = 1024;
	localparam int HEIGHT_BITS = 16;
	localparam int FRAC_BITS   = 16;

	localparam int ADDR_W  = $clog2(MAX_ITEMS);
	localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
	localparam int TOTAL_W = HEIGHT_BITS + ADDR_W;
	localparam int LEVEL_W = HEIGHT_BITS + FRAC_BITS;
	localparam int EXC_W   = LEVEL_W + ADDR_W;
	localparam int TGT_W   = 32 + FRAC_BITS;
	localparam int STEPS   = HEIGHT_BITS + FRAC_BITS;
	localparam int STEP_W  = $clog2(STEPS + 1);

	localparam logic [1:0] ST_EXACT      = 2'd0;
	localparam logic [1:0] ST_IMPOSSIBLE = 2'd1;
	localparam logic [1:0] ST_FOUND      = 2'd2;

	typedef struct packed {
		logic [15:0] height;
		logic [31:0] area;
		logic        is_last;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] cut_level;
	} out_item_t;

endpackage

>>> src/clb_ram.sv
module clb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> src/cut_level_bisection_core.sv
// Heights load one item per cycle into a single-port-read height store.
// A last item starts a fixed 32-step bisection; each step reads every stored
// height once through the store's read port; no search runs when none is needed.
// Input is held off during the search; the result waits in an output register.
// arst_n clears all control state; the height store is not cleared.
module cut_level_bisection_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  clb_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output clb_pkg::out_item_t  out_item
);

	localparam logic [2:0] S_LOAD   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_MID    = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_DRAIN  = 3'd4;
	localparam logic [2:0] S_STEP   = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;
	localparam logic [2:0] S_EMIT   = 3'd7;

	logic [2:0]                          state_q;
	logic [clb_pkg::CNT_W-1:0]           count_q;
	logic [clb_pkg::TOTAL_W-1:0]         total_q;
	logic [clb_pkg::HEIGHT_BITS-1:0]     tallest_q;
	logic [31:0]                         area_q;
	logic [clb_pkg::LEVEL_W-1:0]         lower_q;
	logic [clb_pkg::LEVEL_W-1:0]         upper_q;
	logic [clb_pkg::LEVEL_W-1:0]         mid_q;
	logic [clb_pkg::EXC_W-1:0]           acc_q;
	logic [clb_pkg::STEP_W-1:0]          step_q;
	logic [clb_pkg::CNT_W-1:0]           rd_idx_q;
	logic [1:0]                          res_status_q;
	logic                                out_valid_q;
	clb_pkg::out_item_t                  out_q;

	logic                                rd_vld_s1;
	logic                                diff_vld_s2;
	logic [clb_pkg::LEVEL_W-1:0]         diff_s2;

	logic                                accept;
	logic                                room;
	logic [clb_pkg::HEIGHT_BITS-1:0]     h;
	logic [clb_pkg::HEIGHT_BITS-1:0]     rd_data;
	logic [clb_pkg::LEVEL_W-1:0]         rd_level;
	logic [clb_pkg::LEVEL_W:0]           bound_sum;
	logic [clb_pkg::TGT_W-1:0]           target;

	assign in_ready  = (state_q == S_LOAD);
	assign accept    = in_valid & in_ready;
	assign h         = in_item.height[clb_pkg::HEIGHT_BITS-1:0];
	assign room      = (count_q < clb_pkg::CNT_W'(clb_pkg::MAX_ITEMS));
	assign rd_level  = {rd_data, {clb_pkg::FRAC_BITS{1'b0}}};
	assign bound_sum = {1'b0, lower_q} + {1'b0, upper_q};
	assign target    = {area_q, {clb_pkg::FRAC_BITS{1'b0}}};
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	clb_ram #(
		.WIDTH (clb_pkg::HEIGHT_BITS),
		.DEPTH (clb_pkg::MAX_ITEMS)
	) u_store (
		.clk     (clk),
		.wr_en   (accept & room),
		.wr_addr (count_q[clb_pkg::ADDR_W-1:0]),
		.wr_data (h),
		.rd_en   (state_q == S_SCAN),
		.rd_addr (rd_idx_q[clb_pkg::ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// excess pipeline: store read, then clipped difference, then accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			diff_vld_s2 <= 1'b0;
		end else begin
			rd_vld_s1   <= (state_q == S_SCAN);
			diff_vld_s2 <= rd_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_level > mid_q) begin
			diff_s2 <= rd_level - mid_q;
		end else begin
			diff_s2 <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			count_q      <= '0;
			total_q      <= '0;
			tallest_q    <= '0;
			area_q       <= '0;
			lower_q      <= '0;
			upper_q      <= '0;
			mid_q        <= '0;
			acc_q        <= '0;
			step_q       <= '0;
			rd_idx_q     <= '0;
			res_status_q <= clb_pkg::ST_EXACT;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			if (diff_vld_s2) begin
				acc_q <= acc_q + clb_pkg::EXC_W'(diff_s2);
			end
			case (state_q)
				S_LOAD: begin
					if (accept && room) begin
						count_q <= count_q + 1'b1;
						total_q <= total_q + clb_pkg::TOTAL_W'(h);
						if (h > tallest_q) begin
							tallest_q <= h;
						end
					end
					if (accept && in_item.is_last) begin
						area_q  <= in_item.area;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (64'(total_q) == 64'(area_q)) begin
						res_status_q <= clb_pkg::ST_EXACT;
						state_q      <= S_EMIT;
					end else if (64'(total_q) < 64'(area_q)) begin
						res_status_q <= clb_pkg::ST_IMPOSSIBLE;
						state_q      <= S_EMIT;
					end else begin
						lower_q <= '0;
						upper_q <= {tallest_q, {clb_pkg::FRAC_BITS{1'b0}}};
						step_q  <= '0;
						state_q <= S_MID;
					end
				end
				S_MID: begin
					mid_q    <= bound_sum[clb_pkg::LEVEL_W:1];
					acc_q    <= '0;
					rd_idx_q <= '0;
					if (step_q == clb_pkg::STEP_W'(clb_pkg::STEPS)) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (rd_idx_q == count_q - 1'b1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!rd_vld_s1 && !diff_vld_s2) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (64'(acc_q) > 64'(target)) begin
						lower_q <= mid_q;
					end else begin
						upper_q <= mid_q;
					end
					step_q  <= step_q + 1'b1;
					state_q <= S_MID;
				end
				S_FIN: begin
					if (mid_q[clb_pkg::LEVEL_W-1:clb_pkg::FRAC_BITS] == '0) begin
						res_status_q <= clb_pkg::ST_IMPOSSIBLE;
					end else begin
						res_status_q <= clb_pkg::ST_FOUND;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_q.status <= res_status_q;
						if (res_status_q == clb_pkg::ST_FOUND) begin
							out_q.cut_level <= 32'(mid_q);
						end else begin
							out_q.cut_level <= '0;
						end
						count_q   <= '0;
						total_q   <= '0;
						tallest_q <= '0;
						state_q   <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= clb_pkg::CNT_W'(clb_pkg::MAX_ITEMS))
		else $error("height count beyond store depth");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> rd_idx_q < count_q)
		else $error("scan reads past stored heights");

	a_interval: assert property (@(posedge clk) disable iff (!arst_n)
		lower_q <= upper_q)
		else $error("bisection interval inverted");

	a_step_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_STEP |-> !rd_vld_s1 && !diff_vld_s2)
		else $error("bound update before excess complete");

	a_no_load_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |=> !$rose(in_ready))
		else $error("input opened during scan");
`endif

endmodule

>>> tb/cut_level_bisection_core_tb.sv
`timescale 1ns / 100ps

module cut_level_bisection_core_tb;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int IDLE_PCT    = 38;
	localparam int ITEM_GOAL   = 1800;
	localparam int HOLD_CYCLES = 20000;

	typedef struct {
		bit                 typed;
		clb_pkg::out_item_t want;
	} row_note_t;

	typedef struct {
		logic [15:0] height;
		logic [31:0] area;
		bit          last;
		bit          typed;
		logic [1:0]  status;
		logic [31:0] cut;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	clb_pkg::in_item_t  in_item;
	logic               out_valid;
	logic               out_ready;
	clb_pkg::out_item_t out_item;

	cut_level_bisection_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// predictor state
	logic [15:0]     stored_heights [clb_pkg::MAX_ITEMS];
	int unsigned     stored_count;
	longint unsigned height_sum;
	logic [15:0]     height_peak;

	clb_pkg::out_item_t pending_cuts [$];
	row_note_t          offered_notes [$];

	int unsigned items_offered;
	int unsigned sets_offered;
	int unsigned sets_returned;
	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned hold_left;
	bit          hold_done;

	plan_row_t plan [20] = '{
		'{16'h0000, 32'h0000_0000, 1'b1, 1'b1, clb_pkg::ST_EXACT,      32'd0},
		'{16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, clb_pkg::ST_IMPOSSIBLE, 32'd0},
		'{16'h0001, 32'h0000_0000, 1'b1, 1'b1, clb_pkg::ST_IMPOSSIBLE, 32'd0},
		'{16'h0007, 32'h0000_0007, 1'b1, 1'b1, clb_pkg::ST_EXACT,      32'd0},
		'{16'h0000, 32'h0000_0001, 1'b1, 1'b1, clb_pkg::ST_IMPOSSIBLE, 32'd0},
		'{16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, clb_pkg::ST_EXACT,      32'd0},
		'{16'h0000, 32'h0000_0000, 1'b0, 1'b0, clb_pkg::ST_EXACT,      32'd0},
		'{16'hFFFF, 32'h0000_0000, 1'b1, 1'b0, clb_pkg::ST_EXACT,      32'd0},
		'{16'h000A, 32'h5A5A_5A5A, 1'b0, 1'b0, clb_pkg::ST_EXACT,      32'd0},
		'{16'h0014, 32'hA5A5_A5A5, 1'b0, 1'b0, clb_pkg::ST_EXACT,      32'd0},
		'{16'h001E, 32'h0000_0005, 1'b1, 1'b0, clb_pkg::ST_EXACT,      32'd0},
		'{16'h0003, 32'h0000_0000, 1'b0, 1'b0, clb_pkg::ST_EXACT,      32'd0},
		'{16'h0003, 32'h0000_0006, 1'b1, 1'b1, clb_pkg::ST_EXACT,      32'd0},
		'{16'h0064, 32'h0000_0000, 1'b0, 1'b0, clb_pkg::ST_EXACT,      32'd0},
		'{16'h0000, 32'h0000_0063, 1'b1, 1'b0, clb_pkg::ST_EXACT,      32'd0},
		'{16'h8000, 32'h0000_0000, 1'b0, 1'b0, clb_pkg::ST_EXACT,      32'd0},
		'{16'h7FFF, 32'h0000_0000, 1'b0, 1'b0, clb_pkg::ST_EXACT,      32'd0},
		'{16'h5555, 32'h0000_AAAA, 1'b1, 1'b0, clb_pkg::ST_EXACT,      32'd0},
		'{16'h0002, 32'h0000_0001, 1'b1, 1'b0, clb_pkg::ST_EXACT,      32'd0},
		'{16'hFFFF, 32'h0000_7FFF, 1'b1, 1'b0, clb_pkg::ST_EXACT,      32'd0}
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Loads a height; at set end, bisects for the cut if sum > area.
	function automatic bit predict_cut(clb_pkg::in_item_t it,
		output clb_pkg::out_item_t res);
		logic [63:0] goal, lo, hi, mid, lift, excess;
		res = '0;
		if (stored_count < clb_pkg::MAX_ITEMS) begin
			stored_heights[stored_count] = it.height;
			stored_count++;
			height_sum += it.height;
			if (it.height > height_peak)
				height_peak = it.height;
		end
		if (!it.is_last)
			return 1'b0;
		if (height_sum == it.area) begin
			res.status = clb_pkg::ST_EXACT;
		end else if (height_sum < it.area) begin
			res.status = clb_pkg::ST_IMPOSSIBLE;
		end else begin
			goal = {32'd0, it.area} << clb_pkg::FRAC_BITS;
			lo   = '0;
			hi   = {48'd0, height_peak} << clb_pkg::FRAC_BITS;
			for (int s = 0; s < clb_pkg::STEPS; s++) begin
				mid    = (lo + hi) >> 1;
				excess = '0;
				// 64-bit sum cannot reach saturation for these sizes
				for (int i = 0; i < stored_count; i++) begin
					lift = {48'd0, stored_heights[i]} << clb_pkg::FRAC_BITS;
					if (lift > mid)
						excess += lift - mid;
				end
				if (excess > goal)
					lo = mid;
				else
					hi = mid;
			end
			mid = (lo + hi) >> 1;
			if ((mid >> clb_pkg::FRAC_BITS) == 0) begin
				res.status = clb_pkg::ST_IMPOSSIBLE;
			end else begin
				res.status    = clb_pkg::ST_FOUND;
				res.cut_level = mid[31:0];
			end
		end
		stored_count = 0;
		height_sum   = 0;
		height_peak  = '0;
		return 1'b1;
	endfunction

	task automatic offer_item(clb_pkg::in_item_t it, bit typed, logic [1:0] st,
		logic [31:0] cut);
		row_note_t note;
		note.typed          = typed;
		note.want.status    = st;
		note.want.cut_level = cut;
		while (!(sets_offered >= 40 && sets_offered < 60) && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		offered_notes.push_back(note);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_offered++;
		if (it.is_last)
			sets_offered++;
	endtask

	initial begin : stimulus
		clb_pkg::in_item_t it;
		longint unsigned   stored_total;
		int unsigned       n;
		int unsigned       mode;
		int unsigned       set_no;
		logic [15:0]       h;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_item       = '0;
		stored_count  = 0;
		height_sum    = 0;
		height_peak   = '0;
		items_offered = 0;
		sets_offered  = 0;
		mismatches    = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			it.height  = plan[i].height;
			it.area    = plan[i].area;
			it.is_last = plan[i].last;
			offer_item(it, plan[i].typed, plan[i].status, plan[i].cut);
		end
		in_valid <= 1'b0;
		while (sets_returned != sets_offered)
			@(posedge clk);

		set_no = 0;
		while (items_offered < ITEM_GOAL) begin
			case ($urandom_range(19))
				0:       n = $urandom_range(200, 65);
				1, 2, 3: n = $urandom_range(64, 9);
				default: n = $urandom_range(8, 1);
			endcase
			// one set runs past the store depth
			if (set_no == 25)
				n = clb_pkg::MAX_ITEMS + 1 + $urandom_range(15);
			mode = $urandom_range(3);
			stored_total = 0;
			for (int k = 0; k < n; k++) begin
				case (mode)
					0: h = 16'($urandom());
					1: h = 16'($urandom_range(255));
					2: h = 16'($urandom_range(3));
					default: h = ($urandom_range(2) == 0) ? 16'h0000 :
						($urandom_range(1) == 0) ? 16'hFFFF : 16'($urandom());
				endcase
				if (k < clb_pkg::MAX_ITEMS)
					stored_total += h;
				it.height  = h;
				it.is_last = (k == n - 1);
				it.area    = $urandom();
				if (it.is_last) begin
					case ($urandom_range(9))
						0: it.area = stored_total[31:0];
						1, 2: it.area = $urandom_range(32'hFFFF_FFFF, stored_total[31:0] + 1);
						3: it.area = '0;
						4: it.area = (stored_total > n) ?
							stored_total[31:0] - 1 - $urandom_range(n) : '0;
						default: it.area = (stored_total != 0) ?
							$urandom_range(stored_total[31:0] - 1, 0) : '0;
					endcase
				end
				offer_item(it, 1'b0, clb_pkg::ST_EXACT, '0);
			end
			set_no++;
		end
		in_valid <= 1'b0;

		while (sets_returned != sets_offered)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (pending_cuts.size() != 0) begin
			$error("%0d expected results never arrived", pending_cuts.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("cut_level_bisection_core verification clean");
		else
			$display("cut_level_bisection_core verification failed");
		$finish;
	end

	always @(posedge clk) begin : accept_side
		row_note_t          note;
		clb_pkg::out_item_t res;
		if (arst_n && in_valid && in_ready) begin
			note = offered_notes.pop_front();
			if (predict_cut(in_item, res))
				pending_cuts.push_back(note.typed ? note.want : res);
		end
	end

	always @(posedge clk) begin : result_side
		clb_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_cuts.size() == 0) begin
				$error("result with nothing expected: status %0d cut_level %h",
					out_item.status, out_item.cut_level);
				mismatches++;
			end else begin
				want = pending_cuts.pop_front();
				if (out_item.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_item.status);
					mismatches++;
				end
				if (out_item.cut_level !== want.cut_level) begin
					$error("cut_level: expected %h, got %h", want.cut_level,
						out_item.cut_level);
					mismatches++;
				end
			end
			sets_returned <= sets_returned + 1;
		end
	end

	// receiver: random stalls, a calm window, and one long hold-off
	initial begin
		out_ready     = 1'b0;
		sets_returned = 0;
		hold_left     = 0;
		hold_done     = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!hold_done && sets_returned == 20) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (sets_returned >= 40 && sets_returned < 60) ||
					($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("cut_level_bisection_core verification failed");
				$finish;
			end
		end
	end

endmodule
